/* hw/rtl/circ_pkg.sv */
// Shared types and constants of the circle point generator.
package circ_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned CIN_W   = 15;
  localparam int unsigned RAD_W   = 14;
  localparam int unsigned ERR_W   = 20;
  localparam int unsigned INC_W   = 18;
  localparam int unsigned SUM_W   = 22;
  localparam int unsigned NPTS    = 4;
  localparam int unsigned CNT_W   = $clog2(NPTS + 1);
  localparam int unsigned IDX_W   = $clog2(NPTS);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      done;
  } point_t;

  typedef point_t [NPTS-1:0] point_vec_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] right_x;
    logic signed [COORD_W-1:0] top_y;
    logic signed [COORD_W-1:0] bottom_y;
    logic signed [ERR_W-1:0]   error_term;
    logic signed [INC_W-1:0]   x_increment;
    logic signed [INC_W-1:0]   y_increment;
    logic                      active;
  } circ_state_t;

  localparam circ_state_t STATE_RESET = '{
    left_x:      '0,
    right_x:     '0,
    top_y:       '0,
    bottom_y:    '0,
    error_term:  '0,
    x_increment: INC_W'(1),
    y_increment: INC_W'(1),
    active:      1'b0
  };

endpackage

/* hw/rtl/circ_ifs.sv */
// Valid/ready channel interfaces for the input items and the emitted points.
interface circ_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   op;
  logic signed [circ_pkg::CIN_W-1:0]      center_x;
  logic signed [circ_pkg::CIN_W-1:0]      center_y;
  logic        [circ_pkg::RAD_W-1:0]      radius;
  logic                                   xor_mode;

  modport source (output valid, op, center_x, center_y, radius, xor_mode, input ready);
  modport sink   (input valid, op, center_x, center_y, radius, xor_mode, output ready);
endinterface

interface circ_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [circ_pkg::COORD_W-1:0]    pixel_x;
  logic signed [circ_pkg::COORD_W-1:0]    pixel_y;
  logic                                   last;
  logic                                   done_res;

  modport source (output valid, pixel_x, pixel_y, last, done_res, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last, done_res, output ready);
endinterface

/* hw/rtl/circ_step.sv */
// Next-state and point-set logic for one start or step item.
module circ_step (
  input  circ_pkg::circ_state_t                cur,
  input  logic                                 op,
  input  logic signed [circ_pkg::CIN_W-1:0]    center_x,
  input  logic signed [circ_pkg::CIN_W-1:0]    center_y,
  input  logic        [circ_pkg::RAD_W-1:0]    radius,
  input  logic                                 xor_mode,
  output circ_pkg::circ_state_t                nxt,
  output circ_pkg::point_vec_t                 pts,
  output logic        [circ_pkg::CNT_W-1:0]    cnt
);

  logic signed [circ_pkg::COORD_W-1:0] cx16;
  logic signed [circ_pkg::COORD_W-1:0] cy16;
  logic signed [circ_pkg::COORD_W-1:0] r16;
  logic signed [circ_pkg::COORD_W-1:0] start_top;
  logic signed [circ_pkg::COORD_W-1:0] start_bot;
  logic signed [circ_pkg::SUM_W-1:0]   err_ext;
  logic signed [circ_pkg::SUM_W-1:0]   xinc_ext;
  logic signed [circ_pkg::SUM_W-1:0]   yinc_ext;
  logic signed [circ_pkg::SUM_W-1:0]   exy;
  logic signed [circ_pkg::SUM_W-1:0]   neg_exy;
  logic signed [circ_pkg::SUM_W-1:0]   ex;
  logic signed [circ_pkg::SUM_W-1:0]   neg_e1;
  logic signed [circ_pkg::ERR_W-1:0]   e1;
  logic signed [circ_pkg::ERR_W-1:0]   e2;
  logic                                move_y;
  logic                                move_x;
  logic                                span_open;

  assign cx16      = {center_x[circ_pkg::CIN_W-1], center_x};
  assign cy16      = {center_y[circ_pkg::CIN_W-1], center_y};
  assign r16       = {2'b00, radius};
  assign start_top = cy16 - r16;
  assign start_bot = cy16 + r16;

  assign err_ext  = {{(circ_pkg::SUM_W - circ_pkg::ERR_W){cur.error_term[circ_pkg::ERR_W-1]}},
                     cur.error_term};
  assign xinc_ext = {{(circ_pkg::SUM_W - circ_pkg::INC_W){cur.x_increment[circ_pkg::INC_W-1]}},
                     cur.x_increment};
  assign yinc_ext = {{(circ_pkg::SUM_W - circ_pkg::INC_W){cur.y_increment[circ_pkg::INC_W-1]}},
                     cur.y_increment};

  // The x test compares against the error after a possible y move, but uses
  // the combined sum taken before either move.
  assign exy     = err_ext + xinc_ext + yinc_ext;
  assign neg_exy = -exy;
  assign ex      = err_ext + xinc_ext;
  assign move_y  = neg_exy <= ex;
  assign e1      = move_y ? circ_pkg::ERR_W'(err_ext + yinc_ext) : cur.error_term;
  assign neg_e1  = -{{(circ_pkg::SUM_W - circ_pkg::ERR_W){e1[circ_pkg::ERR_W-1]}}, e1};
  assign move_x  = exy <= neg_e1;
  assign e2      = move_x ? circ_pkg::ERR_W'(e1 + circ_pkg::ERR_W'(xinc_ext)) : e1;

  assign span_open = cur.bottom_y > cur.top_y;

  always_comb begin
    nxt = cur;
    pts = '0;
    cnt = '0;
    if (op == circ_pkg::OP_START) begin
      nxt.left_x      = cx16;
      nxt.right_x     = cx16;
      nxt.top_y       = start_top;
      nxt.bottom_y    = start_bot;
      nxt.error_term  = '0;
      nxt.x_increment = circ_pkg::INC_W'(1);
      nxt.y_increment = circ_pkg::INC_W'(1) - {{(circ_pkg::INC_W - circ_pkg::RAD_W - 1){1'b0}},
                                               radius, 1'b0};
      nxt.active      = 1'b1;
      if (xor_mode) begin
        pts[0] = '{x: cx16, y: start_top, done: 1'b0};
        pts[1] = '{x: cx16, y: start_bot, done: 1'b0};
        cnt    = circ_pkg::CNT_W'(2);
      end
    end else if (cur.active) begin
      if (span_open) begin
        pts[0] = '{x: cur.left_x,  y: cur.top_y,    done: 1'b0};
        pts[1] = '{x: cur.left_x,  y: cur.bottom_y, done: 1'b0};
        pts[2] = '{x: cur.right_x, y: cur.top_y,    done: 1'b0};
        pts[3] = '{x: cur.right_x, y: cur.bottom_y, done: 1'b0};
        cnt    = circ_pkg::CNT_W'(4);
        if (move_y) begin
          nxt.bottom_y    = cur.bottom_y - circ_pkg::COORD_W'(1);
          nxt.top_y       = cur.top_y + circ_pkg::COORD_W'(1);
          nxt.y_increment = cur.y_increment + circ_pkg::INC_W'(2);
        end
        if (move_x) begin
          nxt.right_x     = cur.right_x + circ_pkg::COORD_W'(1);
          nxt.left_x      = cur.left_x - circ_pkg::COORD_W'(1);
          nxt.x_increment = cur.x_increment + circ_pkg::INC_W'(2);
        end
        nxt.error_term = e2;
      end else begin
        pts[0]     = '{x: cur.left_x,  y: cur.top_y, done: 1'b1};
        pts[1]     = '{x: cur.right_x, y: cur.top_y, done: 1'b1};
        cnt        = circ_pkg::CNT_W'(2);
        nxt.active = 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/circ_emit.sv */
// Point buffer that holds the points of one item and sends them one per cycle while the result side is ready.
module circ_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  circ_pkg::point_vec_t         pts,
  input  logic [circ_pkg::CNT_W-1:0]   cnt,
  output logic                         can_load,
  circ_out_if.source                   out_chan
);

  circ_pkg::point_t                buf_r [circ_pkg::NPTS];
  logic [circ_pkg::CNT_W-1:0]      rem_r;
  logic [circ_pkg::CNT_W-1:0]      rem_nxt;
  logic [circ_pkg::IDX_W-1:0]      idx_r;
  logic [circ_pkg::IDX_W-1:0]      idx_nxt;
  logic                            out_xfer;

  assign out_xfer = out_chan.valid && out_chan.ready;
  // A new set may replace the buffer in the cycle its last point transfers.
  assign can_load = (rem_r == '0) || (rem_r == circ_pkg::CNT_W'(1) && out_chan.ready);

  always_comb begin
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    if (load) begin
      rem_nxt = cnt;
      idx_nxt = '0;
    end else if (out_xfer) begin
      rem_nxt = rem_r - circ_pkg::CNT_W'(1);
      idx_nxt = idx_r + circ_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      idx_r <= '0;
    end else begin
      rem_r <= rem_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < circ_pkg::NPTS; i++) begin
        buf_r[i] <= pts[i];
      end
    end
  end

  assign out_chan.valid    = rem_r != '0;
  assign out_chan.pixel_x  = buf_r[idx_r].x;
  assign out_chan.pixel_y  = buf_r[idx_r].y;
  assign out_chan.done_res = buf_r[idx_r].done;
  assign out_chan.last     = rem_r == circ_pkg::CNT_W'(1);

endmodule

/* hw/rtl/circle_point_generator_unit.sv */
// Top level of the circle point generator.
// Traces a circle as a chain of boundary points. A start item (op 0) loads the centre and
// radius and, in XOR mode, sends the top and bottom points; each step item (op 1) sends the
// four symmetric points of the current span and moves the span inward, and once the span has
// closed one more step sends the two closing points with done_res set. The state update for an
// item happens in the cycle it is accepted; its points then leave the point buffer one per
// cycle while the result side is ready. The next item is accepted in the cycle the previous
// item's last point transfers, or at once when no points are pending.
module circle_point_generator_unit (
  input  logic          clk,
  input  logic          rst_n,
  circ_in_if.sink       in_chan,
  circ_out_if.source    out_chan
);

  circ_pkg::circ_state_t                st_r;
  circ_pkg::circ_state_t                st_nxt;
  circ_pkg::point_vec_t                 pts;
  logic [circ_pkg::CNT_W-1:0]           cnt;
  logic                                 can_load;
  logic                                 load;
  logic signed [circ_pkg::COORD_W:0]    span;

  assign in_chan.ready = can_load;
  assign load          = in_chan.valid && in_chan.ready;

  circ_step u_step (
    .cur      (st_r),
    .op       (in_chan.op),
    .center_x (in_chan.center_x),
    .center_y (in_chan.center_y),
    .radius   (in_chan.radius),
    .xor_mode (in_chan.xor_mode),
    .nxt      (st_nxt),
    .pts      (pts),
    .cnt      (cnt)
  );

  circ_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .pts      (pts),
    .cnt      (cnt),
    .can_load (can_load),
    .out_chan (out_chan)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= circ_pkg::STATE_RESET;
    end else if (load) begin
      st_r <= st_nxt;
    end
  end

  assign span = {st_r.bottom_y[circ_pkg::COORD_W-1], st_r.bottom_y}
              - {st_r.top_y[circ_pkg::COORD_W-1], st_r.top_y};

  // A step on a closed span ends the circle.
  a_close_ends: assert property (@(posedge clk) disable iff (!rst_n)
    load && in_chan.op == circ_pkg::OP_STEP && st_r.active && !(st_r.bottom_y > st_r.top_y)
    |=> !st_r.active)
    else $error("closing step left the circle active");

  // Both increments start odd and move by two.
  a_inc_odd: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.x_increment[0] && st_r.y_increment[0])
    else $error("increment lost its odd parity");

  // The span shrinks by two at most, so it never overshoots by more than one.
  a_span_floor: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.active |-> span >= -(circ_pkg::COORD_W + 1)'(1))
    else $error("vertical span overshot while active");

  // No item is taken while more than one point of the previous item is pending.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load && out_chan.valid |-> out_chan.last && out_chan.ready)
    else $error("item accepted over pending points");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for circle_point_generator_unit, with its own circle tracer as predictor.
module tb_top;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TARGET_ITEMS = 300;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE       = 20;

  typedef struct {
    logic signed [circ_pkg::COORD_W-1:0] x;
    logic signed [circ_pkg::COORD_W-1:0] y;
    logic                                last;
    logic                                done;
  } expected_point_t;

  // Traces the circle alongside the block and holds the points it still owes.
  class point_checker_t;
    logic signed [circ_pkg::COORD_W-1:0] left_x, right_x, top_y, bottom_y;
    logic signed [circ_pkg::ERR_W-1:0]   error_term;
    logic signed [circ_pkg::INC_W-1:0]   x_increment, y_increment;
    bit                                  active;
    expected_point_t                     pending_points[$];
    int                                  mismatches, points_seen, starts_seen, circles_closed;

    function new();
      left_x      = '0;
      right_x     = '0;
      top_y       = '0;
      bottom_y    = '0;
      error_term  = '0;
      x_increment = circ_pkg::INC_W'(1);
      y_increment = circ_pkg::INC_W'(1);
      active      = 1'b0;
    endfunction

    function void push(logic signed [circ_pkg::COORD_W-1:0] x,
                       logic signed [circ_pkg::COORD_W-1:0] y,
                       logic last, logic done);
      expected_point_t p;
      p.x    = x;
      p.y    = y;
      p.last = last;
      p.done = done;
      pending_points.push_back(p);
    endfunction

    function void predict_points(circ_pkg::op_t op, logic signed [circ_pkg::CIN_W-1:0] cx,
                                 logic signed [circ_pkg::CIN_W-1:0] cy,
                                 logic [circ_pkg::RAD_W-1:0] r, logic xm);
      int cxi, cyi, ri, e, xi, yi, exy;
      cxi = int'(cx);
      cyi = int'(cy);
      ri  = int'(r);
      if (op == circ_pkg::OP_START) begin
        starts_seen++;
        left_x      = circ_pkg::COORD_W'(cxi);
        right_x     = circ_pkg::COORD_W'(cxi);
        top_y       = circ_pkg::COORD_W'(cyi - ri);
        bottom_y    = circ_pkg::COORD_W'(cyi + ri);
        error_term  = '0;
        x_increment = circ_pkg::INC_W'(1);
        y_increment = circ_pkg::INC_W'(1 - 2 * ri);
        active      = 1'b1;
        if (xm) begin
          push(left_x, top_y, 1'b0, 1'b0);
          push(left_x, bottom_y, 1'b1, 1'b0);
        end
        return;
      end
      if (!active) return;
      if (bottom_y > top_y) begin
        push(left_x, top_y, 1'b0, 1'b0);
        push(left_x, bottom_y, 1'b0, 1'b0);
        push(right_x, top_y, 1'b0, 1'b0);
        push(right_x, bottom_y, 1'b1, 1'b0);
        e   = int'(error_term);
        xi  = int'(x_increment);
        yi  = int'(y_increment);
        exy = e + xi + yi;
        if (-exy <= e + xi) begin
          bottom_y    = circ_pkg::COORD_W'(int'(bottom_y) - 1);
          top_y       = circ_pkg::COORD_W'(int'(top_y) + 1);
          error_term  = circ_pkg::ERR_W'(e + yi);
          y_increment = circ_pkg::INC_W'(yi + 2);
          e           = int'(error_term);
        end
        // The x test keeps the sum taken before the y move but sees the new error.
        if (exy <= -e) begin
          right_x     = circ_pkg::COORD_W'(int'(right_x) + 1);
          left_x      = circ_pkg::COORD_W'(int'(left_x) - 1);
          error_term  = circ_pkg::ERR_W'(e + xi);
          x_increment = circ_pkg::INC_W'(xi + 2);
        end
      end else begin
        push(left_x, top_y, 1'b0, 1'b1);
        push(right_x, top_y, 1'b1, 1'b1);
        active = 1'b0;
        circles_closed++;
      end
    endfunction

    function void note_mismatch(string field, int want, int got);
      mismatches++;
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_point(logic signed [circ_pkg::COORD_W-1:0] x,
                              logic signed [circ_pkg::COORD_W-1:0] y,
                              logic last, logic done);
      expected_point_t want;
      points_seen++;
      if (pending_points.size() == 0) begin
        mismatches++;
        $error("point (%0d, %0d) arrived with no point pending", x, y);
        return;
      end
      want = pending_points.pop_front();
      if (want.x !== x)       note_mismatch("pixel_x", int'(want.x), int'(x));
      if (want.y !== y)       note_mismatch("pixel_y", int'(want.y), int'(y));
      if (want.last !== last) note_mismatch("last", int'(want.last), int'(last));
      if (want.done !== done) note_mismatch("done_res", int'(want.done), int'(done));
    endfunction

    function int outstanding();
      return pending_points.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  bit   hold_req;
  int   taken_count;
  int   items_sent;
  int   cycle_count;

  point_checker_t sb = new();

  circ_in_if  in_if();
  circ_out_if out_if();

  circle_point_generator_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("circle_point_generator_unit regression: fail");
      $finish;
    end
  end

  // Inputs are noted before points so a same-edge transfer on both sides stays in order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        sb.predict_points(circ_pkg::op_t'(in_if.op), in_if.center_x, in_if.center_y,
                          in_if.radius, in_if.xor_mode);
        taken_count++;
      end
      if (out_if.valid && out_if.ready)
        sb.check_point(out_if.pixel_x, out_if.pixel_y, out_if.last, out_if.done_res);
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (!idle_on || roll < 70) return 0;
    if (roll < 96) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = pick_gap();
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Returns in the time step of the transfer, so the next item can follow back to back.
  task automatic send_item(circ_pkg::op_t op, logic signed [circ_pkg::CIN_W-1:0] cx,
                           logic signed [circ_pkg::CIN_W-1:0] cy,
                           logic [circ_pkg::RAD_W-1:0] r, logic xm);
    int target;
    idle_gap();
    if (op == circ_pkg::OP_START || sb.active) items_sent++;
    target = taken_count + 1;
    in_if.valid    <= 1'b1;
    in_if.op       <= op;
    in_if.center_x <= cx;
    in_if.center_y <= cy;
    in_if.radius   <= r;
    in_if.xor_mode <= xm;
    wait (taken_count == target);
  endtask

  // Step items ignore their payload, so it is randomized to toggle the fields.
  task automatic send_step();
    send_item(circ_pkg::OP_STEP, circ_pkg::CIN_W'($urandom()), circ_pkg::CIN_W'($urandom()),
              circ_pkg::RAD_W'($urandom()), 1'($urandom()));
  endtask

  task automatic run_circle(logic signed [circ_pkg::CIN_W-1:0] cx,
                            logic signed [circ_pkg::CIN_W-1:0] cy,
                            logic [circ_pkg::RAD_W-1:0] r, logic xm, int max_steps,
                            int extra_steps);
    int n;
    n = 0;
    send_item(circ_pkg::OP_START, cx, cy, r, xm);
    while (sb.active && n < max_steps) begin
      send_step();
      n++;
    end
    repeat (extra_steps) send_step();
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  initial begin
    int roll, cap;
    logic [circ_pkg::RAD_W-1:0] r;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.op       <= circ_pkg::OP_START;
    in_if.center_x <= '0;
    in_if.center_y <= '0;
    in_if.radius   <= '0;
    in_if.xor_mode <= 1'b0;
    idle_on  = 1'b1;
    hold_req = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a step before any start, zero radius, radius one, the coordinate
    // extremes with the largest radius, a restart mid-circle and steps after closing.
    send_step();
    run_circle(15'sd0, 15'sd0, 14'd0, 1'b1, 4, 1);
    run_circle(-15'sd16384, 15'sd16383, 14'd1, 1'b0, 6, 0);
    run_circle(15'sd16383, -15'sd16384, 14'd16383, 1'b1, 3, 0);
    run_circle(-15'sd16384, 15'sd16383, 14'd16383, 1'b0, 2, 0);
    run_circle(-15'sd1, -15'sd1, 14'd2, 1'b1, 8, 2);
    drain();

    // The result side holds off while steps keep coming, then the sender waits it out.
    idle_on  = 1'b0;
    hold_req = 1'b1;
    run_circle(circ_pkg::CIN_W'($urandom()), circ_pkg::CIN_W'($urandom()), 14'd30, 1'b1,
               60, 0);
    drain();

    while (items_sent < TARGET_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      roll    = int'($urandom_range(0, 99));
      if (roll < 15) begin
        repeat ($urandom_range(1, 4))
          send_item(circ_pkg::op_t'($urandom_range(0, 1)), circ_pkg::CIN_W'($urandom()),
                    circ_pkg::CIN_W'($urandom()), circ_pkg::RAD_W'($urandom()),
                    1'($urandom()));
      end else begin
        roll = int'($urandom_range(0, 99));
        if (roll < 80) begin
          r   = circ_pkg::RAD_W'($urandom_range(0, 15));
          cap = 100;
        end else if (roll < 95) begin
          r   = circ_pkg::RAD_W'($urandom_range(16, 40));
          cap = 100;
        end else begin
          r   = circ_pkg::RAD_W'($urandom());
          cap = int'($urandom_range(1, 12));
        end
        // Now and then the circle is cut short by the next start.
        if ($urandom_range(0, 9) == 0) cap = int'($urandom_range(0, 5));
        run_circle(circ_pkg::CIN_W'($urandom()), circ_pkg::CIN_W'($urandom()), r,
                   1'($urandom()), cap,
                   ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 2)) : 0);
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("Run covered %0d items, %0d circle starts and %0d closed circles,",
             items_sent, sb.starts_seen, sb.circles_closed);
    $display("with %0d points checked under random gaps and a long result hold-off.",
             sb.points_seen);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("circle_point_generator_unit regression: pass");
    end else begin
      $display("circle_point_generator_unit regression: fail");
    end
    $finish;
  end

endmodule
